// ===== rtl/gsfp_pkg.sv =====
package gsfp_pkg;

    localparam int unsigned BODY_BYTES = 29;

    localparam logic [31:0] SYNC_RESET = 32'hFE81_FF55;

    localparam logic [4:0] BODY_LAST   = 5'(BODY_BYTES);
    localparam logic [4:0] POS_X       = 5'd0;
    localparam logic [4:0] POS_Y       = 5'd4;
    localparam logic [4:0] POS_Z       = 5'd8;
    localparam logic [4:0] POS_STATUS  = 5'd24;
    localparam logic [4:0] POS_SEQ     = 5'd25;
    localparam logic [4:0] POS_TEMP    = 5'd26;

    localparam logic [2:0] HIST_FULL   = 3'd4;

    typedef struct packed {
        logic [31:0] rate_x_bits;
        logic [31:0] rate_y_bits;
        logic [31:0] rate_z_bits;
        logic [7:0]  status_byte;
        logic [7:0]  seq_number;
        logic [15:0] temperature_raw;
    } t_frame;

endpackage

// ===== rtl/gsfp_if.sv =====
interface gsfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface gsfp_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] rate_x_bits;
    logic [31:0] rate_y_bits;
    logic [31:0] rate_z_bits;
    logic [7:0]  status_byte;
    logic [7:0]  seq_number;
    logic [15:0] temperature_raw;

    modport source (
        output valid, output rate_x_bits, output rate_y_bits, output rate_z_bits,
        output status_byte, output seq_number, output temperature_raw,
        input ready
    );
    modport sink (
        input valid, input rate_x_bits, input rate_y_bits, input rate_z_bits,
        input status_byte, input seq_number, input temperature_raw,
        output ready
    );
endinterface

// ===== rtl/gyro_serial_frame_parser.sv =====
// Takes one received byte per clock cycle on i_byte unless the input stalls, and hunts for
// the four-byte sync word (first byte in the most significant position, matched only
// after four bytes since reset or since the last frame). After a match the next 29 bytes
// are the frame body and the byte after them ends the frame; one frame beat with the X, Y,
// Z rate words, status, sequence number and temperature then goes into the output buffer
// for o_frame. Each byte passes through the input register before it is decoded into the
// frame registers; a two-entry output buffer lets the byte stream keep flowing while a
// finished frame waits, so the input only stalls when both entries are full and the
// terminator byte is waiting. The sync word resets to 0xFE81FF55; the user must
// write it through i_cfg_wr_en and i_cfg_wr_data while the block is idle (not enforced).
module gyro_serial_frame_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,
    gsfp_byte_if.sink    i_byte,
    gsfp_frame_if.source o_frame
);
    import gsfp_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_pending;
    logic       w_can_accept;
    logic       w_stall;
    logic       w_step;
    logic       w_emit;
    t_frame     w_frame;

    assign w_stall = w_pending && !w_can_accept;
    assign w_step  = w_in_valid && !w_stall;
    assign w_emit  = w_step && w_pending;

    gsfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_stall (w_stall),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    gsfp_frame_fsm u_frame_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_step),
        .i_byte        (w_in_byte),
        .o_pending     (w_pending),
        .o_frame       (w_frame)
    );

    gsfp_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_emit),
        .i_frame      (w_frame),
        .o_can_accept (w_can_accept),
        .o_frame      (o_frame)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_can_accept)
        else $error("frame pushed into a full output buffer");

    a_hunt_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> !w_pending)
        else $error("parser still at frame end after emitting");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_frame.valid) |-> $past(w_emit))
        else $error("output beat appeared without a completed frame");
endmodule

// ===== rtl/gsfp_in_stage.sv =====
module gsfp_in_stage (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gsfp_byte_if.sink i_byte,
    input  logic      i_stall,
    output logic      o_valid,
    output logic [7:0] o_byte
);
    import gsfp_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_take;

    assign i_byte.ready = !r_valid || !i_stall;
    assign w_take       = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_byte.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ===== rtl/gsfp_frame_fsm.sv =====
module gsfp_frame_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [31:0]     i_cfg_wr_data,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output logic            o_pending,
    output gsfp_pkg::t_frame o_frame
);
    import gsfp_pkg::*;

    typedef enum logic {
        ST_HUNT,
        ST_BODY
    } t_state;

    t_state      r_state;
    logic [31:0] r_sync;
    logic [31:0] r_recent;
    logic [2:0]  r_hist_cnt;
    logic [4:0]  r_body_cnt;
    t_frame      r_held;
    logic [31:0] n_recent;
    logic        w_match;

    assign n_recent  = {r_recent[23:0], i_byte};
    assign w_match   = (r_hist_cnt >= HIST_FULL - 3'd1) && (n_recent == r_sync);
    assign o_pending = (r_state == ST_BODY) && (r_body_cnt == BODY_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (i_cfg_wr_en) begin
            r_sync <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HUNT;
            r_hist_cnt <= '0;
            r_body_cnt <= '0;
        end else if (i_step) begin
            case (r_state)
                ST_HUNT: begin
                    if (r_hist_cnt < HIST_FULL) begin
                        r_hist_cnt <= r_hist_cnt + 3'd1;
                    end
                    if (w_match) begin
                        r_state    <= ST_BODY;
                        r_body_cnt <= '0;
                    end
                end
                ST_BODY: begin
                    if (r_body_cnt == BODY_LAST) begin
                        r_state    <= ST_HUNT;
                        r_hist_cnt <= '0;
                    end else begin
                        r_body_cnt <= r_body_cnt + 5'd1;
                    end
                end
                default: begin
                    r_state <= ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && r_state == ST_HUNT) begin
            r_recent <= n_recent;
        end
        if (i_step && r_state == ST_BODY) begin
            case (r_body_cnt) inside
                [POS_X : POS_Y - 5'd1]: begin
                    r_held.rate_x_bits <= {r_held.rate_x_bits[23:0], i_byte};
                end
                [POS_Y : POS_Z - 5'd1]: begin
                    r_held.rate_y_bits <= {r_held.rate_y_bits[23:0], i_byte};
                end
                [POS_Z : POS_Z + 5'd3]: begin
                    r_held.rate_z_bits <= {r_held.rate_z_bits[23:0], i_byte};
                end
                POS_STATUS: begin
                    r_held.status_byte <= i_byte;
                end
                POS_SEQ: begin
                    r_held.seq_number <= i_byte;
                end
                POS_TEMP, POS_TEMP + 5'd1: begin
                    r_held.temperature_raw <= {r_held.temperature_raw[7:0], i_byte};
                end
                default: begin
                end
            endcase
        end
    end

    assign o_frame = r_held;
endmodule

// ===== rtl/gsfp_out_buf.sv =====
module gsfp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gsfp_pkg::t_frame i_frame,
    output logic             o_can_accept,
    gsfp_frame_if.source     o_frame
);
    import gsfp_pkg::*;

    logic   r_v0;
    logic   r_v1;
    t_frame r_d0;
    t_frame r_d1;
    logic   w_free0;

    assign w_free0      = !r_v0 || o_frame.ready;
    assign o_can_accept = !r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (w_free0) begin
            r_v0 <= r_v1 || i_push;
            r_v1 <= r_v1 && i_push;
        end else if (i_push) begin
            r_v1 <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free0) begin
            if (r_v1) begin
                r_d0 <= r_d1;
                if (i_push) begin
                    r_d1 <= i_frame;
                end
            end else if (i_push) begin
                r_d0 <= i_frame;
            end
        end else if (i_push) begin
            r_d1 <= i_frame;
        end
    end

    assign o_frame.valid           = r_v0;
    assign o_frame.rate_x_bits     = r_d0.rate_x_bits;
    assign o_frame.rate_y_bits     = r_d0.rate_y_bits;
    assign o_frame.rate_z_bits     = r_d0.rate_z_bits;
    assign o_frame.status_byte     = r_d0.status_byte;
    assign o_frame.seq_number      = r_d0.seq_number;
    assign o_frame.temperature_raw = r_d0.temperature_raw;
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gsfp_pkg::*;

    localparam logic [4:0] POS_ACCEL    = 5'd12;
    localparam int         IDLE_LIMIT   = 500;
    localparam int         DRAIN_CYCLES = 8;

    typedef enum {BODY_RANDOM, BODY_ZEROS, BODY_ONES, BODY_SYNC_INSIDE} t_body_fill;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    gsfp_byte_if  byte_if ();
    gsfp_frame_if frame_if ();

    gyro_serial_frame_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (byte_if),
        .o_frame       (frame_if)
    );

    always #4 i_clk = ~i_clk;

    logic [7:0] bytes_to_send[$];
    t_frame     frames_due[$];
    int         bytes_queued;
    bit         byte_taken;
    bit         quiet_tail;
    int         src_hold;
    int         sink_hold;
    int         idle_cycles;
    int         mismatches;

    logic [31:0] cur_sync;
    logic [31:0] history;
    logic [2:0]  history_len;
    bit          collecting;
    logic [4:0]  body_pos;
    t_frame      partial;

    function automatic void clear_history();
        history     = '0;
        history_len = '0;
        collecting  = 1'b0;
        body_pos    = '0;
        partial     = '0;
    endfunction

    // Advances the parser by one received byte; returns 1 when a frame completes.
    function automatic bit parse_byte(input logic [7:0] b, output t_frame done);
        done = '0;
        if (!collecting) begin
            history = {history[23:0], b};
            if (history_len < HIST_FULL) begin
                history_len++;
            end
            if (history_len == HIST_FULL && history == cur_sync) begin
                collecting = 1'b1;
                body_pos   = '0;
            end
            return 1'b0;
        end
        if (body_pos < BODY_LAST) begin
            if (body_pos < POS_Y) begin
                partial.rate_x_bits = {partial.rate_x_bits[23:0], b};
            end else if (body_pos < POS_Z) begin
                partial.rate_y_bits = {partial.rate_y_bits[23:0], b};
            end else if (body_pos < POS_ACCEL) begin
                partial.rate_z_bits = {partial.rate_z_bits[23:0], b};
            end else if (body_pos == POS_STATUS) begin
                partial.status_byte = b;
            end else if (body_pos == POS_SEQ) begin
                partial.seq_number = b;
            end else if (body_pos == POS_TEMP || body_pos == 5'(POS_TEMP + 1)) begin
                partial.temperature_raw = {partial.temperature_raw[7:0], b};
            end
            body_pos++;
            return 1'b0;
        end
        done = partial;
        clear_history();
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        bytes_to_send.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void queue_noise(input int count);
        for (int i = 0; i < count; i++) begin
            queue_byte(random_byte());
        end
    endfunction

    function automatic void queue_frame(input logic [31:0] sync, input t_body_fill fill,
                                        input int body_len, input bit ended);
        logic [7:0] b;
        for (int i = 3; i >= 0; i--) begin
            queue_byte(sync[8*i +: 8]);
        end
        for (int i = 0; i < body_len; i++) begin
            case (fill)
                BODY_ZEROS: b = 8'h00;
                BODY_ONES:  b = 8'hFF;
                BODY_SYNC_INSIDE: begin
                    if (i < 4 || (i >= 12 && i < 16)) begin
                        b = sync[8*(3 - i % 4) +: 8];
                    end else begin
                        b = 8'(i * 7 + 1);
                    end
                end
                default: b = random_byte();
            endcase
            queue_byte(b);
        end
        if (ended) begin
            queue_byte(random_byte());
        end
    endfunction

    // Mostly complete frames, with some line noise and some headers cut short.
    function automatic void queue_traffic(input logic [31:0] sync, input int budget);
        int stop_at;
        int cut;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at) begin
            case ($urandom_range(0, 9))
                0: queue_noise($urandom_range(1, 8));
                1: begin
                    cut = $urandom_range(1, 3);
                    for (int i = 3; i >= 4 - cut; i--) begin
                        queue_byte(sync[8*i +: 8]);
                    end
                    queue_byte(random_byte());
                end
                default: begin
                    queue_noise($urandom_range(0, 3));
                    queue_frame(sync, BODY_RANDOM, BODY_BYTES, 1'b1);
                end
            endcase
        end
    endfunction

    task automatic wait_quiet();
        while (bytes_to_send.size() != 0 || byte_if.valid || frames_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_sync = value;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid   <= 1'b0;
            byte_if.rx_byte <= '0;
        end else if (!byte_if.valid || byte_taken) begin
            if (src_hold > 0 && !quiet_tail) begin
                src_hold--;
                byte_if.valid <= 1'b0;
            end else if (bytes_to_send.size() == 0) begin
                byte_if.valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                src_hold = $urandom_range(0, 10);
                byte_if.valid <= 1'b0;
            end else begin
                byte_if.valid   <= 1'b1;
                byte_if.rx_byte <= bytes_to_send.pop_front();
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
        end else if (quiet_tail) begin
            frame_if.ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            frame_if.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            sink_hold = $urandom_range(0, 10);
            frame_if.ready <= 1'b0;
        end else begin
            frame_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_frame want;
        t_frame got;
        if (!i_rst_n) begin
            byte_taken  <= 1'b0;
            idle_cycles <= 0;
        end else begin
            byte_taken <= byte_if.valid && byte_if.ready;
            if (byte_if.valid && byte_if.ready) begin
                if (parse_byte(byte_if.rx_byte, want)) begin
                    frames_due.push_back(want);
                end
            end
            if (frame_if.valid && frame_if.ready) begin
                got.rate_x_bits     = frame_if.rate_x_bits;
                got.rate_y_bits     = frame_if.rate_y_bits;
                got.rate_z_bits     = frame_if.rate_z_bits;
                got.status_byte     = frame_if.status_byte;
                got.seq_number      = frame_if.seq_number;
                got.temperature_raw = frame_if.temperature_raw;
                if (frames_due.size() == 0) begin
                    $error("Frame beat arrived with no frame outstanding.");
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    compare_field("rate_x_bits", want.rate_x_bits, got.rate_x_bits);
                    compare_field("rate_y_bits", want.rate_y_bits, got.rate_y_bits);
                    compare_field("rate_z_bits", want.rate_z_bits, got.rate_z_bits);
                    compare_field("status_byte", 32'(want.status_byte), 32'(got.status_byte));
                    compare_field("seq_number", 32'(want.seq_number), 32'(got.seq_number));
                    compare_field("temperature_raw", 32'(want.temperature_raw),
                                  32'(got.temperature_raw));
                end
            end
            if ((byte_if.valid && byte_if.ready) || (frame_if.valid && frame_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("gyro_serial_frame_parser test failed");
        $finish;
    end

    initial begin
        byte_if.valid   = 1'b0;
        byte_if.rx_byte = '0;
        frame_if.ready  = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_rst_n         = 1'b0;
        cur_sync        = SYNC_RESET;
        clear_history();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The last frame here is left open so the sync word changes in the middle of it.
        queue_noise(3);
        queue_frame(SYNC_RESET, BODY_ONES, BODY_BYTES, 1'b1);
        queue_frame(SYNC_RESET, BODY_ZEROS, BODY_BYTES, 1'b1);
        queue_frame(SYNC_RESET, BODY_SYNC_INSIDE, BODY_BYTES, 1'b1);
        queue_frame(SYNC_RESET, BODY_RANDOM, 10, 1'b0);
        wait_quiet();

        write_sync(32'h0000_0000);
        queue_noise(BODY_BYTES - 10 + 1);
        // A zero sync word must not match until four bytes follow the cleared history.
        for (int i = 0; i < 4; i++) begin
            queue_byte(8'h00);
        end
        queue_noise(BODY_BYTES + 1);
        queue_traffic(32'h0000_0000, 300);
        wait_quiet();

        write_sync(32'hFFFF_FFFF);
        queue_traffic(32'hFFFF_FFFF, 300);
        wait_quiet();

        repeat (2) begin
            write_sync($urandom);
            queue_traffic(cur_sync, 300);
            wait_quiet();
        end

        quiet_tail = 1'b1;
        write_sync(SYNC_RESET);
        queue_traffic(SYNC_RESET, 300);
        wait_quiet();
        repeat (16) @(posedge i_clk);

        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("gyro_serial_frame_parser test passed");
        end else begin
            $display("gyro_serial_frame_parser test failed");
        end
        $finish;
    end

endmodule
